>>> design/mini_risc_execute_unit_macros.svh
// assertion macros used by the checker file
`ifndef MINI_RISC_EXECUTE_UNIT_MACROS_SVH
`define MINI_RISC_EXECUTE_UNIT_MACROS_SVH
// same-cycle implication
`define MRE_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mre check failed");
// next-cycle implication
`define MRE_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mre check failed");
`endif

>>> design/mre_pkg.sv
// ---------------------------------------------------------------------------
// mre_pkg
// shared widths, opcodes and the execute result record of the execute unit
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package mre_pkg;

	localparam int unsigned DATA_WORDS_DEF = 1024;
	localparam int unsigned NUM_REGS       = 32;
	localparam int unsigned REG_W          = 5;
	localparam int unsigned XLEN           = 32;
	localparam int unsigned OP_W           = 5;
	localparam int unsigned IN_TDATA_W     = 64;
	localparam int unsigned IN_TUSER_W     = 5;
	localparam int unsigned OUT_TDATA_W    = 232;
	localparam int unsigned OUT_TUSER_W    = 2;

	typedef enum logic [OP_W-1:0] {
		OP_ADD     = 5'd0,
		OP_ADDI    = 5'd1,
		OP_SUB     = 5'd2,
		OP_SUBI    = 5'd3,
		OP_MUL     = 5'd4,
		OP_MULI    = 5'd5,
		OP_OR      = 5'd6,
		OP_ORI     = 5'd7,
		OP_AND     = 5'd8,
		OP_ANDI    = 5'd9,
		OP_XOR     = 5'd10,
		OP_XORI    = 5'd11,
		OP_LDW     = 5'd12,
		OP_STW     = 5'd13,
		OP_BZ      = 5'd14,
		OP_BEQ     = 5'd15,
		OP_JR      = 5'd16,
		OP_HALT    = 5'd17,
		OP_PRELOAD = 5'd18
	} opcode_t;

	typedef struct packed {
		logic c_arith;
		logic c_logic;
		logic c_mem;
		logic c_ctrl;
	} cls_t;

	typedef struct packed {
		logic             reg_write;
		logic [REG_W-1:0] dest_reg;
		logic [XLEN-1:0]  write_value;
		logic             is_load;
		logic             mem_write;
		logic             dm_we;
		logic             dm_preload;
		logic [XLEN-1:0]  dm_wdata;
		logic [XLEN-1:0]  mem_addr;
		logic [XLEN-1:0]  next_pc;
		logic             taken;
		logic             halt;
		cls_t             cls;
	} exec_t;

	typedef struct packed {
		logic [XLEN-1:0] arith_cnt;
		logic [XLEN-1:0] logic_cnt;
		logic [XLEN-1:0] mem_cnt;
		logic [XLEN-1:0] ctrl_cnt;
	} counts_t;

endpackage

>>> design/mre_regfile.sv
// ---------------------------------------------------------------------------
// mre_regfile
// register file memory, two registered read ports, one write port,
// per-entry valid bits so unwritten registers read as zero after reset
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module mre_regfile (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      rd_en,
	input  logic [mre_pkg::REG_W-1:0] rd_addr_a,
	input  logic [mre_pkg::REG_W-1:0] rd_addr_b,
	output logic [mre_pkg::XLEN-1:0]  rd_data_a,
	output logic [mre_pkg::XLEN-1:0]  rd_data_b,
	input  logic                      wr_en,
	input  logic [mre_pkg::REG_W-1:0] wr_addr,
	input  logic [mre_pkg::XLEN-1:0]  wr_data
);
	import mre_pkg::*;

	logic [XLEN-1:0]     rf_mem [NUM_REGS];
	logic [NUM_REGS-1:0] vld_q;
	logic [XLEN-1:0]     dat_a_q;
	logic [XLEN-1:0]     dat_b_q;
	logic                vld_a_q;
	logic                vld_b_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			rf_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			dat_a_q <= rf_mem[rd_addr_a];
			dat_b_q <= rf_mem[rd_addr_b];
			vld_a_q <= vld_q[rd_addr_a];
			vld_b_q <= vld_q[rd_addr_b];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	assign rd_data_a = vld_a_q ? dat_a_q : '0;
	assign rd_data_b = vld_b_q ? dat_b_q : '0;

endmodule

>>> design/mre_dmem.sv
// ---------------------------------------------------------------------------
// mre_dmem
// word data memory, single address for the write and the registered read
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module mre_dmem #(
	parameter  int unsigned DATA_WORDS = mre_pkg::DATA_WORDS_DEF,
	localparam int unsigned AW         = $clog2(DATA_WORDS)
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [AW-1:0]            addr,
	input  logic [mre_pkg::XLEN-1:0] wdata,
	output logic [mre_pkg::XLEN-1:0] rdata
);
	import mre_pkg::*;

	logic [XLEN-1:0] mem_array [DATA_WORDS];
	logic [XLEN-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_array[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_array[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> design/mre_exec.sv
// ---------------------------------------------------------------------------
// mre_exec
// decode and execute of one instruction: alu, multiplier, address,
// range checks, branch target and instruction class
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module mre_exec #(
	parameter int unsigned DATA_WORDS = mre_pkg::DATA_WORDS_DEF
) (
	input  logic [mre_pkg::OP_W-1:0]  op,
	input  logic [mre_pkg::REG_W-1:0] rt,
	input  logic [mre_pkg::REG_W-1:0] rd,
	input  logic [15:0]               imm,
	input  logic [mre_pkg::XLEN-1:0]  data_word,
	input  logic [mre_pkg::XLEN-1:0]  a,
	input  logic [mre_pkg::XLEN-1:0]  b,
	input  logic [mre_pkg::XLEN-1:0]  pc,
	output mre_pkg::exec_t            ex
);
	import mre_pkg::*;

	logic [XLEN-1:0]  imm_x;
	logic [XLEN-1:0]  opnd;
	logic [XLEN-1:0]  sum;
	logic [XLEN-1:0]  diff;
	logic [XLEN-1:0]  prod;
	logic [XLEN-1:0]  addr;
	logic [XLEN-1:0]  pc4;
	logic [XLEN-1:0]  br_tgt;
	logic [REG_W-1:0] dst;
	logic             in_rng;
	logic             pre_rng;

	assign imm_x   = {{16{imm[15]}}, imm};
	// odd alu opcodes take the immediate
	assign opnd    = op[0] ? imm_x : b;
	assign dst     = op[0] ? rt : rd;
	assign sum     = a + opnd;
	assign diff    = a - opnd;
	assign prod    = a * opnd;
	assign addr    = a + imm_x;
	assign pc4     = pc + 32'd4;
	assign br_tgt  = pc + {imm_x[XLEN-3:0], 2'b00};
	assign in_rng  = {2'b00, addr[XLEN-1:2]} < 32'(DATA_WORDS);
	assign pre_rng = !imm[15] && ({16'd0, imm} < 32'(DATA_WORDS));

	always_comb begin
		ex         = '0;
		ex.next_pc = pc4;
		case (opcode_t'(op))
			OP_ADD, OP_ADDI: begin
				ex.cls.c_arith = 1'b1;
				ex.reg_write   = 1'b1;
				ex.dest_reg    = dst;
				ex.write_value = sum;
			end
			OP_SUB, OP_SUBI: begin
				ex.cls.c_arith = 1'b1;
				ex.reg_write   = 1'b1;
				ex.dest_reg    = dst;
				ex.write_value = diff;
			end
			OP_MUL, OP_MULI: begin
				ex.cls.c_arith = 1'b1;
				ex.reg_write   = 1'b1;
				ex.dest_reg    = dst;
				ex.write_value = prod;
			end
			OP_OR, OP_ORI: begin
				ex.cls.c_logic = 1'b1;
				ex.reg_write   = 1'b1;
				ex.dest_reg    = dst;
				ex.write_value = a | opnd;
			end
			OP_AND, OP_ANDI: begin
				ex.cls.c_logic = 1'b1;
				ex.reg_write   = 1'b1;
				ex.dest_reg    = dst;
				ex.write_value = a & opnd;
			end
			OP_XOR, OP_XORI: begin
				ex.cls.c_logic = 1'b1;
				ex.reg_write   = 1'b1;
				ex.dest_reg    = dst;
				ex.write_value = a ^ opnd;
			end
			OP_LDW: begin
				ex.cls.c_mem  = 1'b1;
				ex.mem_addr   = addr;
				if (in_rng) begin
					ex.reg_write = 1'b1;
					ex.dest_reg  = rt;
					ex.is_load   = 1'b1;
				end
			end
			OP_STW: begin
				ex.cls.c_mem  = 1'b1;
				ex.mem_addr   = addr;
				if (in_rng) begin
					ex.mem_write = 1'b1;
					ex.dm_we     = 1'b1;
					ex.dm_wdata  = b;
				end
			end
			OP_BZ: begin
				ex.cls.c_ctrl = 1'b1;
				if (a == '0) begin
					ex.taken   = 1'b1;
					ex.next_pc = br_tgt;
				end
			end
			OP_BEQ: begin
				ex.cls.c_ctrl = 1'b1;
				if (a == b) begin
					ex.taken   = 1'b1;
					ex.next_pc = br_tgt;
				end
			end
			OP_JR: begin
				ex.cls.c_ctrl = 1'b1;
				ex.next_pc    = a;
			end
			OP_HALT: begin
				ex.cls.c_ctrl = 1'b1;
				ex.halt       = 1'b1;
			end
			OP_PRELOAD: begin
				ex.next_pc = pc;
				if (pre_rng) begin
					ex.dm_we      = 1'b1;
					ex.dm_preload = 1'b1;
					ex.dm_wdata   = data_word;
				end
			end
			default: begin
				ex.next_pc = pc;
			end
		endcase
	end

endmodule

>>> design/mini_risc_execute_unit.sv
// ---------------------------------------------------------------------------
// mini_risc_execute_unit
// stages: register file read, execute and data memory read, output register
// throughput: one instruction per cycle unless the output stalls
// register hazards resolved by forwarding
// reset: pc, counters and pipeline valids cleared, register file reads zero
// through per-entry valid bits; data memory contents are not cleared
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module mini_risc_execute_unit #(
	parameter int unsigned DATA_WORDS = mre_pkg::DATA_WORDS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// rs, rt, rd, imm, data_word
	input  logic [mre_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	// op
	input  logic [mre_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// dest_reg, write_value, mem_addr, next_pc, taken, halt,
	// arith_count, logic_count, mem_count, ctrl_count
	output logic [mre_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	// reg_write, mem_write
	output logic [mre_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);
	import mre_pkg::*;

	localparam int unsigned AW = $clog2(DATA_WORDS);

	logic             s_xfer;
	logic             s1_adv;
	logic             s2_adv;
	logic             s1_valid_q;
	logic             s2_valid_q;
	logic             out_valid_q;

	logic [OP_W-1:0]  op_s1;
	logic [REG_W-1:0] rs_s1;
	logic [REG_W-1:0] rt_s1;
	logic [REG_W-1:0] rd_s1;
	logic [15:0]      imm_s1;
	logic [XLEN-1:0]  dword_s1;

	logic [XLEN-1:0]  rf_a;
	logic [XLEN-1:0]  rf_b;
	logic [XLEN-1:0]  a_fwd;
	logic [XLEN-1:0]  b_fwd;
	logic             s2_hit_a;
	logic             s2_hit_b;
	logic             lw_hit_a;
	logic             lw_hit_b;

	logic             lw_valid_q;
	logic [REG_W-1:0] lw_reg_q;
	logic [XLEN-1:0]  lw_val_q;

	exec_t            ex_s1;
	exec_t            ex_s2;
	logic [XLEN-1:0]  pc_q;
	counts_t          cnt_q;
	counts_t          cnt_nxt;
	counts_t          cnt_s2;

	logic [AW-1:0]    dm_idx;
	logic [XLEN-1:0]  dm_rdata;
	logic [XLEN-1:0]  wb_val;
	logic             rf_we;

	logic [OUT_TDATA_W-1:0] out_tdata_q;
	logic [OUT_TUSER_W-1:0] out_tuser_q;

	// pipeline flow
	assign s2_adv        = s2_valid_q && (!out_valid_q || m_axis_tready);
	assign s1_adv        = s1_valid_q && (!s2_valid_q || s2_adv);
	assign s_axis_tready = !s1_valid_q || s1_adv;
	assign s_xfer        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			s2_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_xfer) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_adv) begin
				s2_valid_q <= 1'b1;
			end else if (s2_adv) begin
				s2_valid_q <= 1'b0;
			end
			if (s2_adv) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_xfer) begin
			op_s1    <= s_axis_tuser[4:0];
			rs_s1    <= s_axis_tdata[4:0];
			rt_s1    <= s_axis_tdata[9:5];
			rd_s1    <= s_axis_tdata[14:10];
			imm_s1   <= s_axis_tdata[30:15];
			dword_s1 <= s_axis_tdata[62:31];
		end
	end

	mre_regfile u_regfile (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (s_xfer),
		.rd_addr_a (s_axis_tdata[4:0]),
		.rd_addr_b (s_axis_tdata[9:5]),
		.rd_data_a (rf_a),
		.rd_data_b (rf_b),
		.wr_en     (rf_we),
		.wr_addr   (ex_s2.dest_reg),
		.wr_data   (wb_val)
	);

	// operand forwarding: stage 2 result first, then the write retired as s1 filled
	assign wb_val   = ex_s2.is_load ? dm_rdata : ex_s2.write_value;
	assign s2_hit_a = s2_valid_q && ex_s2.reg_write && (ex_s2.dest_reg == rs_s1);
	assign s2_hit_b = s2_valid_q && ex_s2.reg_write && (ex_s2.dest_reg == rt_s1);
	assign lw_hit_a = lw_valid_q && (lw_reg_q == rs_s1);
	assign lw_hit_b = lw_valid_q && (lw_reg_q == rt_s1);
	assign a_fwd    = s2_hit_a ? wb_val : (lw_hit_a ? lw_val_q : rf_a);
	assign b_fwd    = s2_hit_b ? wb_val : (lw_hit_b ? lw_val_q : rf_b);
	assign rf_we    = s2_adv && ex_s2.reg_write;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lw_valid_q <= 1'b0;
		end else if (rf_we) begin
			lw_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rf_we) begin
			lw_reg_q <= ex_s2.dest_reg;
			lw_val_q <= wb_val;
		end
	end

	mre_exec #(
		.DATA_WORDS (DATA_WORDS)
	) u_exec (
		.op        (op_s1),
		.rt        (rt_s1),
		.rd        (rd_s1),
		.imm       (imm_s1),
		.data_word (dword_s1),
		.a         (a_fwd),
		.b         (b_fwd),
		.pc        (pc_q),
		.ex        (ex_s1)
	);

	always_comb begin
		cnt_nxt.arith_cnt = cnt_q.arith_cnt + {31'd0, ex_s1.cls.c_arith};
		cnt_nxt.logic_cnt = cnt_q.logic_cnt + {31'd0, ex_s1.cls.c_logic};
		cnt_nxt.mem_cnt   = cnt_q.mem_cnt + {31'd0, ex_s1.cls.c_mem};
		cnt_nxt.ctrl_cnt  = cnt_q.ctrl_cnt + {31'd0, ex_s1.cls.c_ctrl};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q  <= '0;
			cnt_q <= '0;
		end else if (s1_adv) begin
			pc_q  <= ex_s1.next_pc;
			cnt_q <= cnt_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			ex_s2  <= ex_s1;
			cnt_s2 <= cnt_nxt;
		end
	end

	assign dm_idx = ex_s1.dm_preload ? imm_s1[AW-1:0] : ex_s1.mem_addr[AW+1:2];

	mre_dmem #(
		.DATA_WORDS (DATA_WORDS)
	) u_dmem (
		.clk   (clk),
		.we    (s1_adv && ex_s1.dm_we),
		.re    (s1_adv && ex_s1.is_load),
		.addr  (dm_idx),
		.wdata (ex_s1.dm_wdata),
		.rdata (dm_rdata)
	);

	always_ff @(posedge clk) begin
		if (s2_adv) begin
			out_tdata_q <= {1'b0, cnt_s2.ctrl_cnt, cnt_s2.mem_cnt, cnt_s2.logic_cnt,
				cnt_s2.arith_cnt, ex_s2.halt, ex_s2.taken, ex_s2.next_pc,
				ex_s2.mem_addr, wb_val, ex_s2.dest_reg};
			out_tuser_q <= {ex_s2.mem_write, ex_s2.reg_write};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_tdata_q;
	assign m_axis_tuser  = out_tuser_q;

endmodule

>>> design/mre_checker.sv
// ---------------------------------------------------------------------------
// mre_checker
// port-level checks on the result stream of the execute unit
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "mini_risc_execute_unit_macros.svh"
module mre_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tvalid,
	input logic                            s_axis_tready,
	input logic [mre_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	input logic [mre_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [mre_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input logic [mre_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);
	import mre_pkg::*;

	logic in_seen;

	assign in_seen = s_axis_tvalid && s_axis_tready && (s_axis_tuser != '0 || s_axis_tdata != '0);

	// no register write means zero destination and value
	`MRE_ASSERT_IMP(a_nowrite_zero, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata[36:0] == 37'd0)
	// halt writes nothing and never branches
	`MRE_ASSERT_IMP(a_halt_quiet, m_axis_tvalid && m_axis_tdata[102], (m_axis_tuser == 2'b00) && !m_axis_tdata[101] && !in_seen || (m_axis_tuser == 2'b00) && !m_axis_tdata[101])
	// a taken branch writes neither register nor memory
	`MRE_ASSERT_IMP(a_taken_quiet, m_axis_tvalid && m_axis_tdata[101], m_axis_tuser == 2'b00)
	// a stalled transfer holds
	`MRE_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

endmodule

bind mini_risc_execute_unit mre_checker u_mre_checker (.*);

>>> bench/tb_mini_risc_execute_unit.sv
// ---------------------------------------------------------------------------
// tb_mini_risc_execute_unit
// Self-checking bench for the execute unit. A behavioral model of the register
// file, data memory, pc and class counters predicts every result record at the
// input transfer. Results are compared in order as they leave the unit.
// Directed tests cover operand extremes, every opcode, out-of-range and
// wrapping memory addresses, preload index limits, taken and untaken branches
// and unused opcodes. Two long random programs with bursty input and stalling
// output follow. Loads only ever reach words written earlier.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_mini_risc_execute_unit;
	import mre_pkg::*;

	localparam int unsigned MEM_WORDS = DATA_WORDS_DEF;

	typedef struct packed {
		logic [4:0]  op;
		logic [4:0]  rs;
		logic [4:0]  rt;
		logic [4:0]  rd;
		logic [15:0] imm;
		logic [31:0] data_word;
	} instr_t;

	typedef struct packed {
		logic        reg_write;
		logic [4:0]  dest_reg;
		logic [31:0] write_value;
		logic        mem_write;
		logic [31:0] mem_addr;
		logic [31:0] next_pc;
		logic        taken;
		logic        halt;
		logic [31:0] arith_count;
		logic [31:0] logic_count;
		logic [31:0] mem_count;
		logic [31:0] ctrl_count;
	} exec_result_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic [IN_TUSER_W-1:0]  s_axis_tuser;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic [OUT_TUSER_W-1:0] m_axis_tuser;

	logic [31:0] reg_model [NUM_REGS];
	logic [31:0] mem_model [MEM_WORDS];
	bit          mem_written [MEM_WORDS];
	logic [31:0] pc_model;
	logic [31:0] arith_model;
	logic [31:0] logic_model;
	logic [31:0] mem_ops_model;
	logic [31:0] ctrl_model;

	exec_result_t expected_results [$];
	int           mismatch_count = 0;
	int           burst_left = 0;
	int           rx_cycle = 0;
	int           rx_mode = 0;

	mini_risc_execute_unit uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(5_000_000);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// executes one instruction on the model state and returns its result record
	function automatic exec_result_t execute_instr(input instr_t it);
		exec_result_t r;
		logic [31:0]  a;
		logic [31:0]  b;
		logic [31:0]  immx;
		logic [31:0]  res;
		logic [31:0]  addr;
		logic [31:0]  npc;
		logic [31:0]  widx;
		logic [4:0]   dest;
		logic         wr;
		logic         mw;
		logic         tk;
		logic         hl;
		a = reg_model[it.rs];
		b = reg_model[it.rt];
		immx = {{16{it.imm[15]}}, it.imm};
		res = '0;
		addr = '0;
		npc = pc_model + 32'd4;
		dest = '0;
		wr = 1'b0;
		mw = 1'b0;
		tk = 1'b0;
		hl = 1'b0;
		case (it.op)
			OP_ADD: begin arith_model++; dest = it.rd; res = a + b; wr = 1'b1; end
			OP_ADDI: begin arith_model++; dest = it.rt; res = a + immx; wr = 1'b1; end
			OP_SUB: begin arith_model++; dest = it.rd; res = a - b; wr = 1'b1; end
			OP_SUBI: begin arith_model++; dest = it.rt; res = a - immx; wr = 1'b1; end
			OP_MUL: begin arith_model++; dest = it.rd; res = a * b; wr = 1'b1; end
			OP_MULI: begin arith_model++; dest = it.rt; res = a * immx; wr = 1'b1; end
			OP_OR: begin logic_model++; dest = it.rd; res = a | b; wr = 1'b1; end
			OP_ORI: begin logic_model++; dest = it.rt; res = a | immx; wr = 1'b1; end
			OP_AND: begin logic_model++; dest = it.rd; res = a & b; wr = 1'b1; end
			OP_ANDI: begin logic_model++; dest = it.rt; res = a & immx; wr = 1'b1; end
			OP_XOR: begin logic_model++; dest = it.rd; res = a ^ b; wr = 1'b1; end
			OP_XORI: begin logic_model++; dest = it.rt; res = a ^ immx; wr = 1'b1; end
			OP_LDW: begin
				mem_ops_model++;
				addr = a + immx;
				widx = addr >> 2;
				if (widx < MEM_WORDS) begin
					dest = it.rt;
					res = mem_model[widx];
					wr = 1'b1;
				end
			end
			OP_STW: begin
				mem_ops_model++;
				addr = a + immx;
				widx = addr >> 2;
				if (widx < MEM_WORDS) begin
					mem_model[widx] = b;
					mem_written[widx] = 1'b1;
					mw = 1'b1;
				end
			end
			OP_BZ: begin
				ctrl_model++;
				if (a == 32'd0) begin
					npc = pc_model + (immx << 2);
					tk = 1'b1;
				end
			end
			OP_BEQ: begin
				ctrl_model++;
				if (a == b) begin
					npc = pc_model + (immx << 2);
					tk = 1'b1;
				end
			end
			OP_JR: begin ctrl_model++; npc = a; end
			OP_HALT: begin ctrl_model++; hl = 1'b1; end
			OP_PRELOAD: begin
				npc = pc_model;
				if (!it.imm[15] && it.imm < MEM_WORDS) begin
					mem_model[it.imm] = it.data_word;
					mem_written[it.imm] = 1'b1;
				end
			end
			default: npc = pc_model;
		endcase
		if (wr) begin
			reg_model[dest] = res;
		end else begin
			dest = '0;
			res = '0;
		end
		pc_model = npc;
		r.reg_write = wr;
		r.dest_reg = dest;
		r.write_value = res;
		r.mem_write = mw;
		r.mem_addr = addr;
		r.next_pc = npc;
		r.taken = tk;
		r.halt = hl;
		r.arith_count = arith_model;
		r.logic_count = logic_model;
		r.mem_count = mem_ops_model;
		r.ctrl_count = ctrl_model;
		return r;
	endfunction

	task automatic send_instr(input instr_t it);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			burst_left = $urandom_range(1, 24);
			repeat (gap) begin
				@(negedge clk);
				s_axis_tvalid = 1'b0;
			end
		end
		burst_left--;
		@(negedge clk);
		s_axis_tvalid = 1'b1;
		s_axis_tdata = {1'b0, it.data_word, it.imm, it.rd, it.rt, it.rs};
		s_axis_tuser = it.op;
		do @(posedge clk); while (!s_axis_tready);
		expected_results.push_back(execute_instr(it));
	endtask

	// a load of a word never written gets a preload of that word ahead of it
	task automatic issue(input logic [4:0] op, input logic [4:0] rs, input logic [4:0] rt,
			input logic [4:0] rd, input logic [15:0] imm, input logic [31:0] dw);
		instr_t      it;
		logic [31:0] addr;
		addr = reg_model[rs] + {{16{imm[15]}}, imm};
		if (op == OP_LDW && (addr >> 2) < MEM_WORDS && !mem_written[addr >> 2]) begin
			it = '{op: OP_PRELOAD, rs: rs, rt: rt, rd: rd, imm: 16'(addr >> 2),
				data_word: $urandom};
			send_instr(it);
		end
		it = '{op: op, rs: rs, rt: rt, rd: rd, imm: imm, data_word: dw};
		send_instr(it);
	endtask

	task automatic wait_results_done();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	function automatic logic [15:0] rand_imm();
		case ($urandom_range(0, 15))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return 16'hffff;
			3: return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			mismatch_count++;
			$error("%s: expected %h, actual %h", name, want, got);
		end
	endtask

	always @(posedge clk) begin
		exec_result_t want;
		exec_result_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.dest_reg = m_axis_tdata[4:0];
			got.write_value = m_axis_tdata[36:5];
			got.mem_addr = m_axis_tdata[68:37];
			got.next_pc = m_axis_tdata[100:69];
			got.taken = m_axis_tdata[101];
			got.halt = m_axis_tdata[102];
			got.arith_count = m_axis_tdata[134:103];
			got.logic_count = m_axis_tdata[166:135];
			got.mem_count = m_axis_tdata[198:167];
			got.ctrl_count = m_axis_tdata[230:199];
			got.reg_write = m_axis_tuser[0];
			got.mem_write = m_axis_tuser[1];
			if (expected_results.size() == 0) begin
				mismatch_count++;
				$error("result transfer with no instruction outstanding");
			end else begin
				want = expected_results.pop_front();
				check_field("reg_write", 32'(want.reg_write), 32'(got.reg_write));
				check_field("dest_reg", 32'(want.dest_reg), 32'(got.dest_reg));
				check_field("write_value", want.write_value, got.write_value);
				check_field("mem_write", 32'(want.mem_write), 32'(got.mem_write));
				check_field("mem_addr", want.mem_addr, got.mem_addr);
				check_field("next_pc", want.next_pc, got.next_pc);
				check_field("taken", 32'(want.taken), 32'(got.taken));
				check_field("halt", 32'(want.halt), 32'(got.halt));
				check_field("arith_count", want.arith_count, got.arith_count);
				check_field("logic_count", want.logic_count, got.logic_count);
				check_field("mem_count", want.mem_count, got.mem_count);
				check_field("ctrl_count", want.ctrl_count, got.ctrl_count);
			end
		end
	end

	// output stall pattern, switching at random among four styles
	always @(negedge clk) begin
		rx_cycle++;
		if (rx_cycle % 200 == 0)
			rx_mode = $urandom_range(0, 3);
		case (rx_mode)
			0: m_axis_tready = 1'b1;
			1: m_axis_tready = 1'($urandom_range(0, 1));
			2: m_axis_tready = (rx_cycle % 7) < 3;
			default: m_axis_tready = ($urandom_range(0, 15) != 0);
		endcase
	end

	task automatic test_preload_edges();
		issue(OP_PRELOAD, 5'd0, 5'd0, 5'd0, 16'd0, 32'h8000_0000);
		issue(OP_PRELOAD, 5'd31, 5'd31, 5'd31, 16'd1023, 32'hffff_ffff);
		issue(OP_PRELOAD, 5'd0, 5'd0, 5'd0, 16'hffff, 32'h7fff_ffff);
		issue(OP_PRELOAD, 5'd0, 5'd0, 5'd0, 16'd1024, 32'h1234_5678);
	endtask

	task automatic test_alu_ops();
		issue(OP_ADDI, 5'd0, 5'd1, 5'd0, 16'h7fff, 32'd0);
		issue(OP_ADDI, 5'd0, 5'd2, 5'd0, 16'h8000, 32'd0);
		issue(OP_ADD, 5'd1, 5'd2, 5'd3, 16'd0, 32'd0);
		issue(OP_SUB, 5'd2, 5'd1, 5'd4, 16'd0, 32'd0);
		issue(OP_SUBI, 5'd2, 5'd5, 5'd0, 16'h7fff, 32'd0);
		issue(OP_MUL, 5'd2, 5'd2, 5'd6, 16'd0, 32'd0);
		issue(OP_MULI, 5'd1, 5'd7, 5'd0, 16'h8000, 32'd0);
		issue(OP_OR, 5'd1, 5'd2, 5'd8, 16'd0, 32'd0);
		issue(OP_ORI, 5'd1, 5'd9, 5'd0, 16'h8000, 32'd0);
		issue(OP_AND, 5'd2, 5'd1, 5'd10, 16'd0, 32'd0);
		issue(OP_ANDI, 5'd2, 5'd11, 5'd0, 16'hffff, 32'd0);
		issue(OP_XOR, 5'd2, 5'd1, 5'd31, 16'd0, 32'd0);
		issue(OP_XORI, 5'd1, 5'd0, 5'd0, 16'h8000, 32'd0);
	endtask

	task automatic test_memory_access();
		issue(OP_STW, 5'd12, 5'd2, 5'd0, 16'd4092, 32'd0);
		issue(OP_LDW, 5'd12, 5'd13, 5'd0, 16'd4095, 32'd0);
		issue(OP_LDW, 5'd12, 5'd14, 5'd0, 16'hfffc, 32'd0);
		issue(OP_STW, 5'd12, 5'd1, 5'd0, 16'd4096, 32'd0);
	endtask

	task automatic test_control_flow();
		issue(OP_BZ, 5'd15, 5'd0, 5'd0, 16'hfffd, 32'd0);
		issue(OP_BEQ, 5'd1, 5'd2, 5'd0, 16'h7fff, 32'd0);
		issue(OP_BEQ, 5'd2, 5'd2, 5'd0, 16'h8000, 32'd0);
		issue(OP_JR, 5'd3, 5'd0, 5'd0, 16'd0, 32'd0);
		issue(OP_HALT, 5'd0, 5'd0, 5'd0, 16'd0, 32'd0);
	endtask

	task automatic test_unused_opcodes();
		issue(5'd19, 5'd1, 5'd2, 5'd3, 16'h1234, 32'hdead_beef);
		issue(5'd31, 5'd31, 5'd31, 5'd31, 16'hffff, 32'hffff_ffff);
	endtask

	task automatic test_random_program(input int count);
		int          kind;
		logic [4:0]  op;
		logic [4:0]  rs;
		logic [4:0]  rt;
		logic [4:0]  rd;
		logic [15:0] imm;
		logic [31:0] target;
		logic [31:0] offset;
		for (int n = 0; n < count; n++) begin
			kind = $urandom_range(0, 99);
			rs = 5'($urandom);
			rt = 5'($urandom);
			rd = 5'($urandom);
			imm = rand_imm();
			if (kind < 35) begin
				op = 5'($urandom_range(OP_ADD, OP_XORI));
				issue(op, rs, rt, rd, imm, $urandom);
			end else if (kind < 55) begin
				op = $urandom_range(0, 1) ? OP_LDW : OP_STW;
				target = $urandom_range(0, MEM_WORDS * 4 - 1);
				offset = target - reg_model[rs];
				if ($signed(offset) > 32767 || $signed(offset) < -32768) begin
					issue(OP_ANDI, rs, rs, rd, 16'h0ffc, $urandom);
					offset = target - reg_model[rs];
				end
				issue(op, rs, rt, rd, offset[15:0], $urandom);
				if (op == OP_STW && $urandom_range(0, 2) == 0)
					issue(OP_LDW, rs, 5'($urandom), rd, offset[15:0], $urandom);
			end else if (kind < 62) begin
				op = $urandom_range(0, 1) ? OP_LDW : OP_STW;
				issue(op, rs, rt, rd, imm, $urandom);
			end else if (kind < 70) begin
				if ($urandom_range(0, 7) != 0)
					imm = 16'($urandom_range(0, MEM_WORDS - 1));
				issue(OP_PRELOAD, rs, rt, rd, imm, $urandom);
			end else if (kind < 84) begin
				if ($urandom_range(0, 1) == 0)
					imm = 16'($signed($urandom_range(0, 64)) - 32);
				if ($urandom_range(0, 1) == 0) begin
					if ($urandom_range(0, 1) == 0)
						issue(OP_XOR, rs, rs, rs, 16'd0, $urandom);
					issue(OP_BZ, rs, rt, rd, imm, $urandom);
				end else begin
					if ($urandom_range(0, 1) == 0)
						rt = rs;
					issue(OP_BEQ, rs, rt, rd, imm, $urandom);
				end
			end else if (kind < 90) begin
				issue(OP_JR, rs, rt, rd, imm, $urandom);
			end else if (kind < 95) begin
				issue(OP_HALT, rs, rt, rd, imm, $urandom);
			end else begin
				issue(5'($urandom_range(19, 31)), rs, rt, rd, imm, $urandom);
			end
		end
	endtask

	// input side holds off until the unit has returned every result
	task automatic test_drain_pause();
		for (int n = 0; n < 12; n++)
			issue(5'($urandom_range(OP_ADD, OP_XORI)), 5'($urandom), 5'($urandom),
				5'($urandom), rand_imm(), $urandom);
		wait_results_done();
		repeat ($urandom_range(2, 10)) @(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		foreach (reg_model[i])
			reg_model[i] = '0;
		foreach (mem_model[i]) begin
			mem_model[i] = '0;
			mem_written[i] = 1'b0;
		end
		pc_model = '0;
		arith_model = '0;
		logic_model = '0;
		mem_ops_model = '0;
		ctrl_model = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_preload_edges();
		test_alu_ops();
		test_memory_access();
		test_control_flow();
		test_unused_opcodes();
		test_random_program(520);
		test_drain_pause();
		test_random_program(520);

		wait_results_done();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
